### sv/spa_pkg.sv
package spa_pkg;

    localparam int MAX_CHANNELS_DEF = 64;
    localparam int MAX_SAMPLES_DEF  = 256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam int EW = 22;
    localparam int TW = 30;

    localparam logic [EW-1:0] E_MAX     = '1;
    localparam logic [TW-1:0] T_MAX     = '1;
    localparam logic [16:0]   SCORE_ONE = 17'h10000;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_NUM_CHANNELS = 3'd0;
    localparam logic [2:0] REG_NUM_SAMPLES  = 3'd1;
    localparam logic [2:0] REG_TARGET_INDEX = 3'd2;
    localparam logic [2:0] REG_MAX_SHIFT    = 3'd3;
    localparam logic [2:0] REG_MIN_SCORE    = 3'd4;

    typedef struct packed {
        logic [6:0]  num_channels;
        logic [8:0]  num_samples;
        logic [7:0]  target_index;
        logic [7:0]  max_shift;
        logic [16:0] min_score_q16;
    } spa_cfg_t;

    // Summary of one finished snippet, handed from the front to the back.
    typedef struct packed {
        logic          started;
        logic [8:0]    best_offset;
        logic [EW-1:0] best_energy;
        logic [TW-1:0] total_energy;
    } spa_rec_t;

endpackage

### sv/spa_queue.sv
module spa_queue
    import spa_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  spa_rec_t       push_data,
    input  logic           pop,
    output spa_rec_t       pop_data,
    output logic           not_empty,
    output logic [QCW-1:0] count
);

    spa_rec_t       mem [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign pop_data  = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> 32'(count_reg) < QUEUE_DEPTH)
        else $error("snippet queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("snippet queue underflow");

endmodule

### sv/spa_front.sv
module spa_front
    import spa_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  spa_cfg_t            cfg,
    input  logic signed [15:0]  sample_value,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  logic [QCW-1:0]      q_count,
    output logic                push,
    output spa_rec_t            push_data
);

    localparam int CCW  = $clog2(MAX_CHANNELS + 1);
    localparam int SCW  = $clog2(MAX_SAMPLES + 1);
    localparam int CMPW = (SCW > 9) ? SCW : 9;

    logic [CCW-1:0] chan_reg, chan_next;
    logic [SCW-1:0] smp_reg, smp_next;

    logic [CCW-1:0]  nch;
    logic [SCW-1:0]  nsm;
    logic [CMPW-1:0] lo, hi_raw, last_idx, smp_ext;
    logic            last_ch, last_smp, in_win, accept;

    logic          a_valid_reg, a_last_ch_reg, a_last_smp_reg, a_in_win_reg;
    logic [16:0]   a_mag_reg;
    logic [8:0]    a_idx_reg;

    logic [EW-1:0] acc_reg, acc_next;
    logic [EW-1:0] best_reg, best_next, best_new;
    logic [8:0]    off_reg, off_next, off_new;
    logic [TW-1:0] total_reg, total_next, total_new;
    logic          started_reg, started_next, started_new;

    logic [EW:0]   e_sum;
    logic [EW-1:0] e;
    logic [TW:0]   t_sum;
    logic          upd, better, pending;

    // Clamp the counts to the supported range.
    assign nch = (cfg.num_channels == '0) ? CCW'(1) :
                 ((32'(cfg.num_channels) > MAX_CHANNELS) ? CCW'(MAX_CHANNELS) :
                  CCW'(cfg.num_channels));
    assign nsm = (cfg.num_samples == '0) ? SCW'(1) :
                 ((32'(cfg.num_samples) > MAX_SAMPLES) ? SCW'(MAX_SAMPLES) :
                  SCW'(cfg.num_samples));

    assign lo       = (cfg.target_index >= cfg.max_shift) ?
                      CMPW'(cfg.target_index - cfg.max_shift) : '0;
    assign hi_raw   = CMPW'({1'b0, cfg.target_index} + {1'b0, cfg.max_shift});
    assign last_idx = CMPW'(nsm - 1'b1);
    assign smp_ext  = CMPW'(smp_reg);

    assign last_ch  = ((CCW+1)'(chan_reg) + 1'b1) >= (CCW+1)'(nch);
    assign last_smp = ((SCW+1)'(smp_reg) + 1'b1) >= (SCW+1)'(nsm);
    assign in_win   = (smp_ext >= lo) && (smp_ext <= hi_raw) && (smp_ext <= last_idx);

    // A beat in the first stage that ends a snippet still owes the queue one entry.
    assign pending      = a_valid_reg && a_last_ch_reg && a_last_smp_reg;
    assign sample_ready = (32'(q_count) + 32'(pending)) < QUEUE_DEPTH;
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        chan_next = chan_reg;
        smp_next  = smp_reg;
        if (accept)
        begin
            if (!last_ch)
            begin
                chan_next = chan_reg + 1'b1;
            end
            else
            begin
                chan_next = '0;
                smp_next  = last_smp ? '0 : smp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg       <= '0;
            smp_reg        <= '0;
            a_valid_reg    <= 1'b0;
            a_last_ch_reg  <= 1'b0;
            a_last_smp_reg <= 1'b0;
            a_in_win_reg   <= 1'b0;
            a_mag_reg      <= '0;
            a_idx_reg      <= '0;
        end
        else
        begin
            chan_reg    <= chan_next;
            smp_reg     <= smp_next;
            a_valid_reg <= accept;
            if (accept)
            begin
                a_last_ch_reg  <= last_ch;
                a_last_smp_reg <= last_smp;
                a_in_win_reg   <= in_win;
                a_mag_reg      <= sample_value[15] ? (SCORE_ONE - {1'b0, sample_value})
                                                   : {1'b0, sample_value};
                a_idx_reg      <= 9'(smp_reg);
            end
        end
    end

    // Second stage: per-sample energy, peak tracking and window total.
    assign e_sum  = {1'b0, acc_reg} + (EW+1)'(a_mag_reg);
    assign e      = e_sum[EW] ? E_MAX : e_sum[EW-1:0];
    assign t_sum  = {1'b0, total_reg} + (TW+1)'(e);
    assign upd    = a_valid_reg && a_last_ch_reg && a_in_win_reg;
    assign better = !started_reg || (e > best_reg);

    assign best_new    = (upd && better) ? e : best_reg;
    assign off_new     = (upd && better) ? a_idx_reg : off_reg;
    assign started_new = started_reg || upd;
    assign total_new   = upd ? (t_sum[TW] ? T_MAX : t_sum[TW-1:0]) : total_reg;

    assign push                   = pending;
    assign push_data.started      = started_new;
    assign push_data.best_offset  = off_new;
    assign push_data.best_energy  = best_new;
    assign push_data.total_energy = total_new;

    always_comb
    begin
        acc_next     = acc_reg;
        best_next    = best_reg;
        off_next     = off_reg;
        total_next   = total_reg;
        started_next = started_reg;
        if (a_valid_reg)
        begin
            if (!a_last_ch_reg)
            begin
                acc_next = e;
            end
            else if (a_last_smp_reg)
            begin
                acc_next     = '0;
                best_next    = '0;
                off_next     = '0;
                total_next   = '0;
                started_next = 1'b0;
            end
            else
            begin
                acc_next     = '0;
                best_next    = best_new;
                off_next     = off_new;
                total_next   = total_new;
                started_next = started_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            best_reg    <= '0;
            off_reg     <= '0;
            total_reg   <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            best_reg    <= best_next;
            off_reg     <= off_next;
            total_reg   <= total_next;
            started_reg <= started_next;
        end
    end

    a_clear_after_snippet: assert property (@(posedge clk) disable iff (!rst_n)
        pending |=> !started_reg && total_reg == '0 && acc_reg == '0)
        else $error("snippet state not cleared after its last beat");

endmodule

### sv/spa_back.sv
module spa_back
    import spa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  spa_cfg_t           cfg,
    input  logic               q_valid,
    input  spa_rec_t           q_data,
    output logic               pop,
    output logic signed [8:0]  raw_shift,
    output logic               accepted,
    output logic signed [8:0]  applied_shift,
    output logic [21:0]        peak_energy,
    output logic [29:0]        window_energy,
    output logic               result_valid,
    input  logic               result_ready
);

    logic [16:0] score;

    logic          s1_valid_reg;
    logic [8:0]    s1_raw_reg;
    logic [EW-1:0] s1_peak_reg;
    logic [TW-1:0] s1_total_reg;
    logic [31:0]   s1_pp_lo_reg, s1_pp_hi_reg;
    logic          s1_zero_score_reg;

    logic          s2_valid_reg;
    logic [8:0]    s2_raw_reg;
    logic [EW-1:0] s2_peak_reg;
    logic [TW-1:0] s2_total_reg;
    logic [46:0]   s2_prod_reg;
    logic          s2_zero_score_reg;

    logic          out_valid_reg;
    logic [8:0]    out_raw_reg;
    logic          out_acc_reg;
    logic [EW-1:0] out_peak_reg;
    logic [TW-1:0] out_total_reg;

    logic out_load, s2_load, s1_load, acc_next;
    logic [47:0] lhs;

    assign score = (cfg.min_score_q16 > SCORE_ONE) ? SCORE_ONE : cfg.min_score_q16;

    assign out_load = !out_valid_reg || result_ready;
    assign s2_load  = !s2_valid_reg || out_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign pop      = q_valid && s1_load;

    // The 17 x 30 bit product is split into two 17 x 15 bit partial products.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_raw_reg        <= q_data.started ?
                                 9'(q_data.best_offset - {1'b0, cfg.target_index}) : '0;
            s1_peak_reg       <= q_data.started ? q_data.best_energy : '0;
            s1_total_reg      <= q_data.total_energy;
            s1_pp_lo_reg      <= {15'b0, score} * {17'b0, q_data.total_energy[14:0]};
            s1_pp_hi_reg      <= {15'b0, score} * {17'b0, q_data.total_energy[29:15]};
            s1_zero_score_reg <= (score == '0);
        end
        if (s2_load)
        begin
            s2_raw_reg        <= s1_raw_reg;
            s2_peak_reg       <= s1_peak_reg;
            s2_total_reg      <= s1_total_reg;
            s2_prod_reg       <= {s1_pp_hi_reg, 15'b0} + 47'(s1_pp_lo_reg);
            s2_zero_score_reg <= s1_zero_score_reg;
        end
        if (out_load)
        begin
            out_raw_reg   <= s2_raw_reg;
            out_acc_reg   <= acc_next;
            out_peak_reg  <= s2_peak_reg;
            out_total_reg <= s2_total_reg;
        end
    end

    assign lhs      = {10'b0, s2_peak_reg, 16'b0};
    assign acc_next = (s2_total_reg == '0) ? s2_zero_score_reg : (lhs >= {1'b0, s2_prod_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= q_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign raw_shift     = out_raw_reg;
    assign accepted      = out_acc_reg;
    assign applied_shift = out_acc_reg ? out_raw_reg : '0;
    assign peak_energy   = out_peak_reg;
    assign window_energy = out_total_reg;

    a_peak_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_total_reg == '0) == (out_peak_reg == '0))
        else $error("peak and window energy disagree on an empty window");

endmodule

### sv/spike_snippet_peak_aligner.sv
// The last value of a snippet passes the first-stage register, the 4-entry snippet
// queue, s1, s2 and the output register before its result beat is valid. The front
// takes one value per cycle while sample_ready is high; the back pipeline drains one
// snippet summary per cycle while result_ready allows. Reset (rst_n low, asynchronous)
// restores the register defaults and clears all snippet state, the queue and result_valid.
module spike_snippet_peak_aligner
    import spa_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic signed [15:0] sample_value,
    input  logic               sample_valid,
    output logic               sample_ready,
    output logic signed [8:0]  raw_shift,
    output logic               accepted,
    output logic signed [8:0]  applied_shift,
    output logic [21:0]        peak_energy,
    output logic [29:0]        window_energy,
    output logic               result_valid,
    input  logic               result_ready
);

    spa_cfg_t       cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    logic           push, pop, q_valid;
    spa_rec_t       push_data, q_data;
    logic [QCW-1:0] q_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels  <= 7'd4;
            cfg_reg.num_samples   <= 9'd32;
            cfg_reg.target_index  <= 8'd16;
            cfg_reg.max_shift     <= 8'd3;
            cfg_reg.min_score_q16 <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_NUM_CHANNELS: cfg_reg.num_channels  <= pwdata[6:0];
                REG_NUM_SAMPLES:  cfg_reg.num_samples   <= pwdata[8:0];
                REG_TARGET_INDEX: cfg_reg.target_index  <= pwdata[7:0];
                REG_MAX_SHIFT:    cfg_reg.max_shift     <= pwdata[7:0];
                REG_MIN_SCORE:    cfg_reg.min_score_q16 <= pwdata[16:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NUM_CHANNELS: prdata = 32'(cfg_reg.num_channels);
            REG_NUM_SAMPLES:  prdata = 32'(cfg_reg.num_samples);
            REG_TARGET_INDEX: prdata = 32'(cfg_reg.target_index);
            REG_MAX_SHIFT:    prdata = 32'(cfg_reg.max_shift);
            REG_MIN_SCORE:    prdata = 32'(cfg_reg.min_score_q16);
            default:          prdata = '0;
        endcase
    end

    spa_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_value (sample_value),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .q_count      (q_count),
        .push         (push),
        .push_data    (push_data)
    );

    spa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .not_empty (q_valid),
        .count     (q_count)
    );

    spa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .raw_shift     (raw_shift),
        .accepted      (accepted),
        .applied_shift (applied_shift),
        .peak_energy   (peak_energy),
        .window_energy (window_energy),
        .result_valid  (result_valid),
        .result_ready  (result_ready)
    );

endmodule
